FILE: hw/rtl/linear_interp_resampler_defines.svh
// Assertion macros shared by the resampler RTL.
// Each expands to one labeled concurrent assertion clocked on clk and held off
// during reset.
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Same-cycle implication.
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT
	} lir_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take_first;  // first sample: store as prior, no result
		logic take_skip;   // position beyond this pair: store, drop one unit
		logic take_run;    // latch current sample and differences
		logic mul;         // form fraction times difference
		logic emit;        // load output beat, advance position
	} lir_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic have_prior;
		logic offset_ge_one;
		logic out_free;
		logic run_done;
	} lir_sts_t;

endpackage

FILE: hw/rtl/linear_interp_resampler.sv
`timescale 1ns / 1ps
// Channel  Signals                                      Beat
// in       in_valid/in_ready, left_in, right_in         one stereo input sample
// out      out_valid/out_ready, left_out, right_out,    one interpolated sample,
//          run_last                                     run_last on last of input
// cfg      cfg_wr_en, cfg_index, cfg_data               one register write
//
// Sequence: an input beat whose pair brackets n output positions (0 to 4) runs
//   the multiply and emit steps once per output before the next input beat is
//   taken; each output passes the product register stage, then loads the output
//   register. A first sample or a beat with no outputs is handled in idle alone.
// Reset: arst_n clears the controller, read position, prior-valid flag and
//   the output valid flag, and returns phase_step to 1.0 and mono_source to 0.
// Stalls: a held output beat holds the datapath in the emit step; the input
//   side stays closed until the last output of the current beat is loaded.
`include "linear_interp_resampler_defines.svh"

module linear_interp_resampler
	import lir_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          run_last,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [FRAC_BITS+2:0]          cfg_data
);

	localparam int O_W = FRAC_BITS + 3;
	localparam logic [O_W-1:0] STEP_RESET = O_W'(1) << FRAC_BITS;

	lir_cmd_t   cmd;
	lir_sts_t   sts;
	lir_state_t state;

	logic [O_W-1:0] phase_step_q;
	logic           mono_source_q;

	// Configuration registers; the datapath clamps the step to 0.25..4.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= STEP_RESET;
			mono_source_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PHASE_STEP: begin
					phase_step_q <= cfg_data;
				end
				REG_MONO_SOURCE: begin
					mono_source_q <= cfg_data[0];
				end
				default: begin
					phase_step_q <= phase_step_q;
				end
			endcase
		end
	end

	// Sequencer: accept, then multiply and emit once per output position.
	lir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	// Prior sample, read position, per-channel multiply and output register.
	lir_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.phase_step  (phase_step_q),
		.mono_source (mono_source_q),
		.left_in     (left_in),
		.right_in    (right_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_out    (left_out),
		.right_out   (right_out),
		.run_last    (run_last)
	);

	// The multiply step only runs on a position inside the current pair.
	`LIR_ASSERT_NOW(a_mul_in_pair, state == ST_MUL, !sts.offset_ge_one, "multiply past pair")
	// Never overwrite an output beat that has not been taken.
	`LIR_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "output overwritten")
	// A first sample yields no result and leaves the sequencer idle.
	`LIR_ASSERT_NEXT(a_first_idle, in_valid && in_ready && !sts.have_prior,
		state == ST_IDLE && sts.have_prior, "first sample started a run")

endmodule

FILE: hw/rtl/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl
	import lir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  lir_sts_t   sts,
	output lir_cmd_t   cmd,
	output lir_state_t state
);

	lir_state_t state_q;
	lir_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.have_prior && !sts.offset_ge_one) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.run_done ? ST_IDLE : ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.take_first = in_valid && !sts.have_prior;
				cmd.take_skip  = in_valid && sts.have_prior && sts.offset_ge_one;
				cmd.take_run   = in_valid && sts.have_prior && !sts.offset_ge_one;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign state = state_q;

endmodule

FILE: hw/rtl/lir_datapath.sv
`timescale 1ns / 1ps

module lir_datapath
	import lir_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lir_cmd_t                      cmd,
	output lir_sts_t                      sts,
	input  logic [FRAC_BITS+2:0]          phase_step,
	input  logic                          mono_source,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          run_last
);

	localparam int S   = SAMPLE_BITS;
	localparam int F   = FRAC_BITS;
	localparam int O_W = F + 3;
	localparam int P_W = S + F + 2;
	localparam logic [O_W-1:0] ONE      = O_W'(1) << F;
	localparam logic [O_W-1:0] STEP_MIN = O_W'(1) << (F - 2);
	localparam logic [O_W-1:0] STEP_MAX = O_W'(4) << F;
	localparam logic [P_W-1:0] HALF     = P_W'(1) << (F - 1);

	logic signed [S-1:0] cur_l, cur_r;
	logic signed [S-1:0] prior_l_q, prior_r_q, cur_l_q, cur_r_q;
	logic signed [S:0]   diff_l_q, diff_r_q;
	logic signed [P_W-1:0] prod_l_s1, prod_r_s1;
	logic [P_W-1:0] rnd_l, rnd_r;
	logic [O_W-1:0] offset_q, step_c, next_off;
	logic have_prior_q, out_valid_q, run_last_q;
	logic signed [S-1:0] left_q, right_q;
	logic signed [F:0] frac;

	assign cur_l = left_in;
	assign cur_r = mono_source ? left_in : right_in;

	always_comb begin
		if (phase_step < STEP_MIN) begin
			step_c = STEP_MIN;
		end else if (phase_step > STEP_MAX) begin
			step_c = STEP_MAX;
		end else begin
			step_c = phase_step;
		end
	end

	assign next_off = offset_q + step_c;
	assign frac     = $signed({1'b0, offset_q[F-1:0]});
	assign rnd_l    = prod_l_s1 + HALF;
	assign rnd_r    = prod_r_s1 + HALF;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prior_q <= 1'b0;
			offset_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.take_first) begin
				have_prior_q <= 1'b1;
			end
			if (cmd.take_skip) begin
				offset_q <= offset_q - ONE;
			end else if (cmd.emit) begin
				offset_q <= next_off[F +: 3] != 3'd0 ? next_off - ONE : next_off;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sample path
	always_ff @(posedge clk) begin
		if (cmd.take_first || cmd.take_skip) begin
			prior_l_q <= cur_l;
			prior_r_q <= cur_r;
		end else if (cmd.emit && sts.run_done) begin
			prior_l_q <= cur_l_q;
			prior_r_q <= cur_r_q;
		end
		if (cmd.take_run) begin
			cur_l_q  <= cur_l;
			cur_r_q  <= cur_r;
			diff_l_q <= {cur_l[S-1], cur_l} - {prior_l_q[S-1], prior_l_q};
			diff_r_q <= {cur_r[S-1], cur_r} - {prior_r_q[S-1], prior_r_q};
		end
		if (cmd.mul) begin
			prod_l_s1 <= frac * diff_l_q;
			prod_r_s1 <= frac * diff_r_q;
		end
		if (cmd.emit) begin
			left_q     <= prior_l_q + $signed(rnd_l[F +: S]);
			right_q    <= prior_r_q + $signed(rnd_r[F +: S]);
			run_last_q <= sts.run_done;
		end
	end

	assign sts.have_prior    = have_prior_q;
	assign sts.offset_ge_one = offset_q[F +: 3] != 3'd0;
	assign sts.out_free      = !out_valid_q || out_ready;
	assign sts.run_done      = next_off[F +: 3] != 3'd0;

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign run_last  = run_last_q;

endmodule

FILE: bench/tb_linear_interp_resampler.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler;
	import lir_pkg::*;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS = 16;
	localparam int STEP_W = FRAC_BITS + 3;
	localparam longint UNIT_POS = longint'(1) << FRAC_BITS;
	localparam longint STEP_FLOOR = UNIT_POS / 4;
	localparam longint STEP_CEIL = UNIT_POS * 4;
	localparam int MAX_PER_INPUT = 4;
	// Leave room after the longest input beat for a zero-output beat in flight.
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 56;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam sample_t S_ZERO = '0;
	localparam sample_t S_NEG1 = '1;

	typedef struct {
		sample_t left;
		sample_t right;
	} stereo_t;

	typedef struct {
		sample_t left;
		sample_t right;
		logic    last;
	} interp_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	sample_t              left_in = '0;
	sample_t              right_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	sample_t              left_out;
	sample_t              right_out;
	logic                 run_last;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PHASE_STEP;
	logic [STEP_W-1:0]    cfg_data = '0;

	// Input samples waiting for the driver, and interpolated beats still owed by the block
	stereo_t      sample_queue[$];
	interp_beat_t interp_due[$];

	// Shadow of the resampler: register copies and stream state
	logic [STEP_W-1:0] shadow_step = STEP_W'(UNIT_POS);
	logic              shadow_mono = 1'b0;
	sample_t           prior_l = '0;
	sample_t           prior_r = '0;
	longint            read_pos = 0;
	logic              primed = 1'b0;

	int          in_gap = 0;
	int          stall_left = 0;
	logic        steady = 1'b0;
	int          fail_count = 0;
	int unsigned cycle_count = 0;

	linear_interp_resampler #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.left_in  (left_in),
		.right_in (right_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out (left_out),
		.right_out(right_out),
		.run_last (run_last),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// s0 + frac*(s1 - s0), product scaled down by the fraction width and rounded
	// half up; arithmetic shift of the biased product gives the floor.
	function automatic sample_t interp_point(input sample_t s0, input sample_t s1,
			input longint frac);
		longint acc;
		acc = frac * (longint'(s1) - longint'(s0)) + UNIT_POS / 2;
		return sample_t'(longint'(s0) + (acc >>> FRAC_BITS));
	endfunction

	// Work out every beat one accepted input sample brings about and queue it.
	function automatic void predict_interp(input sample_t l, input sample_t r_raw);
		sample_t      r;
		longint       step;
		int           n;
		interp_beat_t b;
		// Mono: left replaces right before use and before it is stored
		r = shadow_mono ? l : r_raw;
		step = longint'(shadow_step);
		if (step < STEP_FLOOR)
			step = STEP_FLOOR;
		if (step > STEP_CEIL)
			step = STEP_CEIL;
		// First sample only primes the pair
		if (!primed) begin
			prior_l = l;
			prior_r = r;
			primed = 1'b1;
			return;
		end
		// Emit every position that falls before the current sample; a position of
		// one unit or more yields nothing and just drops by one unit below
		n = 0;
		while (read_pos < UNIT_POS && n < MAX_PER_INPUT) begin
			b.left = interp_point(prior_l, l, read_pos);
			b.right = interp_point(prior_r, r, read_pos);
			b.last = (read_pos + step >= UNIT_POS) || (n == MAX_PER_INPUT - 1);
			interp_due.push_back(b);
			read_pos += step;
			n++;
		end
		read_pos -= UNIT_POS;
		prior_l = l;
		prior_r = r;
	endfunction

	// Idle length: mostly none, often short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t pick_sample(input int kind, input sample_t base);
		sample_t v;
		if (kind < 4) begin
			v = sample_t'($urandom);
		end else if (kind < 6) begin
			case ($urandom_range(0, 3))
				0: v = S_MAX;
				1: v = S_MIN;
				2: v = S_ZERO;
				default: v = S_NEG1;
			endcase
		end else if (kind < 8) begin
			// Slow wander around the last value, wrapping freely
			v = base + sample_t'($urandom_range(0, 2047)) - sample_t'(1024);
		end else begin
			v = sample_t'($urandom_range(0, 511)) - sample_t'(256);
		end
		return v;
	endfunction

	function automatic void queue_sample(input sample_t l, input sample_t r);
		stereo_t s;
		s.left = l;
		s.right = r;
		sample_queue.push_back(s);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait until every sample is taken and every owed beat has come out, then let
	// a beat with no outputs finish inside the block. Look at the negative edge so
	// the driver's pop and the check never meet in one step.
	task automatic settle();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || in_valid || interp_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: hold the beat until taken, then idle for the drawn gap.
	always @(posedge clk) begin : sample_drive
		stereo_t s;
		logic    nxt_valid;
		nxt_valid = in_valid;
		if (arst_n && (!in_valid || in_ready)) begin
			nxt_valid = 1'b0;
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
			end else if (sample_queue.size() > 0) begin
				s = sample_queue.pop_front();
				left_in <= s.left;
				right_in <= s.right;
				nxt_valid = 1'b1;
				in_gap <= steady ? 0 : idle_len();
			end
		end
		in_valid <= nxt_valid;
	end

	// Output side: accept, then stall for a drawn number of cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= steady ? 0 : idle_len();
		end
	end

	// Monitor: mirror register writes, predict on every input beat, check every
	// output beat against the oldest owed one.
	always @(posedge clk) begin : beat_check
		interp_beat_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PHASE_STEP: shadow_step = cfg_data;
					REG_MONO_SOURCE: shadow_mono = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_interp(left_in, right_in);
			if (out_valid && out_ready) begin
				if (interp_due.size() == 0) begin
					$error("output beat with nothing owed: left_out %0d right_out %0d run_last %0b",
						left_out, right_out, run_last);
					fail_count++;
				end else begin
					want = interp_due.pop_front();
					if (left_out !== want.left) begin
						$error("left_out: expected %0d, got %0d", want.left, left_out);
						fail_count++;
					end
					if (right_out !== want.right) begin
						$error("right_out: expected %0d, got %0d", want.right, right_out);
						fail_count++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0b, got %0b", want.last, run_last);
						fail_count++;
					end
				end
			end
		end
	end

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		sample_t           drift_l;
		sample_t           drift_r;
		int                kind;
		logic [STEP_W-1:0] step_pick;
		drift_l = '0;
		drift_r = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers, unit step: every output lands on the prior sample.
		// The first beat only primes the pair.
		queue_sample(S_ZERO, S_ZERO);
		queue_sample(S_MAX, S_MIN);
		queue_sample(S_MIN, S_MAX);
		queue_sample(S_NEG1, sample_t'(1));
		queue_sample(S_MAX, S_MAX);
		queue_sample(S_ZERO, S_ZERO);
		settle();

		// Step below range clamps to a quarter: four beats per input, full-scale
		// swings through the product. Mono ignores the right input.
		write_reg(REG_PHASE_STEP, '0);
		write_reg(REG_MONO_SOURCE, STEP_W'(1));
		queue_sample(S_MIN, sample_t'(5));
		queue_sample(S_MAX, sample_t'(-7));
		queue_sample(S_ZERO, S_MAX);
		queue_sample(sample_t'(1), S_MIN);
		queue_sample(S_NEG1, S_ZERO);
		settle();

		// Step above range clamps to four: most inputs yield nothing.
		write_reg(REG_PHASE_STEP, '1);
		write_reg(REG_MONO_SOURCE, STEP_W'(0));
		queue_sample(S_MAX, S_MIN);
		queue_sample(S_MIN, S_MAX);
		queue_sample(sample_t'(1), S_NEG1);
		queue_sample(S_ZERO, S_ZERO);
		queue_sample(S_MAX, S_ZERO);
		queue_sample(S_MIN, S_ZERO);
		settle();

		// Half step, changed while the position is still ahead: odd differences
		// put the product exactly on a rounding tie, both signs.
		write_reg(REG_PHASE_STEP, STEP_W'(UNIT_POS / 2));
		queue_sample(S_ZERO, S_ZERO);
		queue_sample(sample_t'(1), S_NEG1);
		queue_sample(S_ZERO, S_ZERO);
		queue_sample(S_NEG1, sample_t'(1));
		queue_sample(S_MIN, S_MAX);
		queue_sample(S_MAX, S_MIN);
		settle();

		// Random phases: sweep the step across its range and past both clamps,
		// flip mono, and run some phases with no idling on either side.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 8)
				0: step_pick = STEP_W'(STEP_FLOOR);
				1: step_pick = STEP_W'(STEP_CEIL);
				2: step_pick = STEP_W'($urandom_range(STEP_FLOOR, STEP_CEIL));
				3: step_pick = STEP_W'($urandom);
				4: step_pick = STEP_W'($urandom_range(60000, 70000));
				5: step_pick = STEP_W'($urandom_range(STEP_FLOOR, 40000));
				6: step_pick = STEP_W'($urandom_range(0, STEP_FLOOR - 1));
				default: step_pick = STEP_W'($urandom_range(STEP_CEIL + 1, (1 << STEP_W) - 1));
			endcase
			write_reg(REG_PHASE_STEP, step_pick);
			write_reg(REG_MONO_SOURCE, STEP_W'(p % 3 == 1));
			steady = (p % 4 == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				kind = $urandom_range(0, 9);
				drift_l = pick_sample(kind, drift_l);
				drift_r = pick_sample(kind, drift_r);
				queue_sample(drift_l, drift_r);
			end
			settle();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
